// File: rtl/strong_connectivity_check_defines.svh
// assertion macros for the strong connectivity checker
// used by the checker module only; needs clk and rst_n in scope
`ifndef STRONG_CONNECTIVITY_CHECK_DEFINES_SVH
`define STRONG_CONNECTIVITY_CHECK_DEFINES_SVH

// same-cycle implication
`define SCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/scc_pkg.sv
// shared constants, codes and control structs for the strong connectivity checker
// no dependencies
package scc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = 11;
    localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
    localparam int STK_W     = NODE_W + ECNT_W;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CHECK = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic edge_wr;
        logic edge_clr;
        logic sweep_start;
        logic rev_val;
        logic sweep_step;
        logic walk_init;
        logic latch_b;
        logic skip;
        logic push;
        logic pop;
        logic stack_load;
        logic out_load;
        logic out_ok;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic sweep_done;
        logic scan_end;
        logic edge_match;
        logic mark_free;
        logic last_node;
        logic count_full;
        logic rev;
        logic out_busy;
    } sts_t;

endpackage

// File: rtl/strong_connectivity_check.sv
// add edge, clear and the unused code are accepted back to back
// check: s_tready drops; each walk resets the marks of nodes 0 to 1024, then scans the stored
//   edges of each reached node; the verdict is loaded after the last walk once the output is free
// throughput: one transaction at a time, the next is accepted once the verdict is loaded
// reset: asynchronous active low; clears edge count, drop flag, node count to 1, output
module strong_connectivity_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // edge_from [10:0], edge_to [21:11], zero pad
    input  logic [1:0]  s_tuser,   // func [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // strongly_connected [0], edge_error [1], zero pad
);

    scc_pkg::cmd_t cmd;
    scc_pkg::sts_t sts;

    // sequencer
    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and arithmetic
    scc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .edge_from (s_tdata[10:0]),
        .edge_to   (s_tdata[21:11]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/scc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/scc_datapath.sv
// datapath: edge memory, node marks, walk stack, counters and result register
// depends on scc_pkg and scc_ram
module scc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [scc_pkg::NODE_W-1:0]  cfg_wdata,
    input  logic [scc_pkg::NODE_W-1:0]  edge_from,
    input  logic [scc_pkg::NODE_W-1:0]  edge_to,
    input  scc_pkg::cmd_t               cmd,
    output scc_pkg::sts_t               sts,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata
);

    localparam int NW = scc_pkg::NODE_W;
    localparam int CW = scc_pkg::ECNT_W;
    localparam int EAW = $clog2(scc_pkg::MAX_EDGES);
    localparam int MAW = $clog2(scc_pkg::MAX_NODES + 1);
    localparam int SAW = $clog2(scc_pkg::MAX_NODES);

    logic [NW-1:0] node_count_reg;
    logic [CW-1:0] edges_held_reg;
    logic          dropped_reg;
    logic          rev_reg;
    logic [NW-1:0] sweep_reg;
    logic [NW-1:0] top_reg;
    logic [CW-1:0] cur_reg;
    logic [NW-1:0] depth_reg;
    logic [NW-1:0] fin_reg;
    logic [NW-1:0] b_reg;
    logic          m_tvalid_reg;
    logic [1:0]    res_reg;

    logic [NW-1:0] cnt;
    logic          add_ok;
    logic [2*NW-1:0] edge_rdata;
    logic [NW-1:0] a_node;
    logic [NW-1:0] b_node;
    logic          mark_rdata;
    logic          mark_we;
    logic [MAW-1:0] mark_waddr;
    logic          mark_wdata;
    logic [scc_pkg::STK_W-1:0] stk_rdata;
    logic [NW-1:0] depth_m1;
    logic [NW-1:0] depth_m2;
    logic [CW-1:0] cur_p1;

    // effective node count
    always_comb
    begin
        priority if (node_count_reg == '0)
            cnt = NW'(1);
        else if (node_count_reg > NW'(scc_pkg::MAX_NODES))
            cnt = NW'(scc_pkg::MAX_NODES);
        else
            cnt = node_count_reg;
    end

    assign add_ok = (edge_from != '0) && (edge_from <= cnt) && (edge_to != '0)
                  && (edge_to <= cnt) && (edges_held_reg < CW'(scc_pkg::MAX_EDGES));

    // edge memory, source in upper half, destination in lower half
    scc_ram #(.WIDTH(2 * NW), .DEPTH(scc_pkg::MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (cmd.edge_wr && add_ok),
        .waddr (edges_held_reg[EAW-1:0]),
        .wdata ({edge_from, edge_to}),
        .raddr (cur_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    assign a_node = rev_reg ? edge_rdata[NW-1:0] : edge_rdata[2*NW-1:NW];
    assign b_node = rev_reg ? edge_rdata[2*NW-1:NW] : edge_rdata[NW-1:0];

    // node visited marks, swept at the start of each walk
    assign mark_we    = cmd.sweep_step || cmd.push;
    assign mark_waddr = cmd.sweep_step ? sweep_reg[MAW-1:0] : b_reg[MAW-1:0];
    assign mark_wdata = cmd.sweep_step ? (sweep_reg == NW'(1)) : 1'b1;

    scc_ram #(.WIDTH(1), .DEPTH(scc_pkg::MAX_NODES + 1)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (b_node[MAW-1:0]),
        .rdata (mark_rdata)
    );

    // walk stack of saved node and resume position
    assign depth_m1 = depth_reg - NW'(1);
    assign depth_m2 = depth_reg - NW'(2);
    assign cur_p1   = cur_reg + CW'(1);

    scc_ram #(.WIDTH(scc_pkg::STK_W), .DEPTH(scc_pkg::MAX_NODES)) u_stack_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (depth_m1[SAW-1:0]),
        .wdata ({top_reg, cur_p1}),
        .raddr (depth_m2[SAW-1:0]),
        .rdata (stk_rdata)
    );

    // edge bookkeeping and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NW'(1);
            edges_held_reg <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.edge_clr)
            begin
                edges_held_reg <= '0;
                dropped_reg    <= 1'b0;
            end
            else if (cmd.edge_wr)
            begin
                if (add_ok)
                    edges_held_reg <= edges_held_reg + CW'(1);
                else
                    dropped_reg <= 1'b1;
            end
        end
    end

    // walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg   <= 1'b0;
            sweep_reg <= '0;
            top_reg   <= '0;
            cur_reg   <= '0;
            depth_reg <= '0;
            fin_reg   <= '0;
            b_reg     <= '0;
        end
        else
        begin
            if (cmd.sweep_start)
            begin
                rev_reg   <= cmd.rev_val;
                sweep_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + NW'(1);
            end
            if (cmd.latch_b)
            begin
                b_reg <= b_node;
            end
            if (cmd.walk_init)
            begin
                top_reg   <= NW'(1);
                cur_reg   <= '0;
                depth_reg <= NW'(1);
                fin_reg   <= '0;
            end
            else if (cmd.push)
            begin
                top_reg   <= b_reg;
                cur_reg   <= '0;
                depth_reg <= depth_reg + NW'(1);
            end
            else if (cmd.skip)
            begin
                cur_reg <= cur_p1;
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_m1;
                fin_reg   <= fin_reg + NW'(1);
            end
            else if (cmd.stack_load)
            begin
                top_reg <= stk_rdata[scc_pkg::STK_W-1:CW];
                cur_reg <= stk_rdata[CW-1:0];
            end
        end
    end

    // result register toward the output side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg <= {dropped_reg, cmd.out_ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_reg};

    // status
    assign sts.sweep_done = (sweep_reg == NW'(scc_pkg::MAX_NODES));
    assign sts.scan_end   = (cur_reg >= edges_held_reg);
    assign sts.edge_match = (a_node == top_reg) && (b_node != '0) && (b_node <= cnt);
    assign sts.mark_free  = !mark_rdata;
    assign sts.last_node  = (depth_reg == NW'(1));
    assign sts.count_full = (fin_reg == cnt);
    assign sts.rev        = rev_reg;
    assign sts.out_busy   = m_tvalid_reg && !m_tready;

endmodule

// File: rtl/scc_ctrl.sv
// controller state machine sequencing edge loads, mark sweeps and both walks
// depends on scc_pkg
module scc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    func,
    input  scc_pkg::sts_t sts,
    output scc_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SWEEP    = 8'b0000_0010,
        ST_RD_EDGE  = 8'b0000_0100,
        ST_CHK_EDGE = 8'b0000_1000,
        ST_CHK_MARK = 8'b0001_0000,
        ST_POP_RD   = 8'b0010_0000,
        ST_END_WALK = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (func == scc_pkg::FUNC_ADD)
                        cmd.edge_wr = 1'b1;
                    else if (func == scc_pkg::FUNC_CLEAR)
                        cmd.edge_clr = 1'b1;
                    else if (func == scc_pkg::FUNC_CHECK)
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.rev_val     = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    else
                        cmd = '0;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_RD_EDGE;
                end
            end
            ST_RD_EDGE:
            begin
                if (sts.scan_end)
                begin
                    cmd.pop    = 1'b1;
                    state_next = sts.last_node ? ST_END_WALK : ST_POP_RD;
                end
                else
                begin
                    state_next = ST_CHK_EDGE;
                end
            end
            ST_CHK_EDGE:
            begin
                cmd.latch_b = 1'b1;
                if (sts.edge_match)
                begin
                    state_next = ST_CHK_MARK;
                end
                else
                begin
                    cmd.skip   = 1'b1;
                    state_next = ST_RD_EDGE;
                end
            end
            ST_CHK_MARK:
            begin
                if (sts.mark_free)
                    cmd.push = 1'b1;
                else
                    cmd.skip = 1'b1;
                state_next = ST_RD_EDGE;
            end
            ST_POP_RD:
            begin
                cmd.stack_load = 1'b1;
                state_next     = ST_RD_EDGE;
            end
            ST_END_WALK:
            begin
                if (sts.rev && sts.count_full)
                begin
                    cmd.sweep_start = 1'b1;
                    cmd.rev_val     = 1'b0;
                    state_next      = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = sts.count_full && !sts.rev;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/scc_checker.sv
// port-level checks on the strong connectivity checker, bound to the top level
// depends on scc_pkg and strong_connectivity_check_defines.svh
`include "strong_connectivity_check_defines.svh"

module scc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds
    `SCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a result appears only out of a busy check
    `SCC_ASSERT_NOW(a_result_from_check, $rose(m_tvalid), !$past(s_tready))

    // the input side goes busy only after accepting a check transaction
    `SCC_ASSERT_NOW(a_busy_after_check, $fell(s_tready),
        $past(s_tvalid) && $past(s_tuser) == scc_pkg::FUNC_CHECK)

    // result padding stays zero
    `SCC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:2] == 6'd0)

endmodule

bind strong_connectivity_check scc_checker u_scc_checker (.*);

// File: sim/strong_connectivity_check_checker.sv
// checker for the strong connectivity block: predicts each check verdict and compares
// depends on scc_pkg for sizes and function codes
`timescale 1ns / 100ps

module strong_connectivity_check_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // edge_from [10:0], edge_to [21:11], zero pad
    input  logic [1:0]  s_tuser,   // func [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // strongly_connected [0], edge_error [1], zero pad
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic connected;
        logic dropped;
    } verdict_t;

    verdict_t    verdict_q [$];
    logic [10:0] src_mem [scc_pkg::MAX_EDGES];
    logic [10:0] dst_mem [scc_pkg::MAX_EDGES];
    int          edges_held;
    bit          dropped_flag;
    logic [10:0] node_reg;
    int          mismatches;

    // depth-first walk from node 1, returns the number of finished nodes
    function automatic int walk_count(bit rev, int cnt);
        byte marks [scc_pkg::MAX_NODES+1];
        int  stk [scc_pkg::MAX_NODES];
        int  cur [scc_pkg::MAX_NODES];
        int  depth;
        int  top;
        int  e;
        int  a;
        int  b;
        int  done;
        bit  found;
        for (int i = 0; i <= scc_pkg::MAX_NODES; i++)
            marks[i] = 0;
        done = 0;
        marks[1] = 1;
        stk[0] = 1;
        cur[0] = 0;
        depth = 1;
        while (depth > 0)
        begin
            top = stk[depth-1];
            found = 0;
            for (e = cur[depth-1]; e < edges_held; e++)
            begin
                a = rev ? int'(dst_mem[e]) : int'(src_mem[e]);
                b = rev ? int'(src_mem[e]) : int'(dst_mem[e]);
                if (a == top && b >= 1 && b <= cnt && marks[b] == 0)
                begin
                    cur[depth-1] = e + 1;
                    marks[b] = 1;
                    if (depth < scc_pkg::MAX_NODES)
                    begin
                        stk[depth] = b;
                        cur[depth] = 0;
                        depth++;
                    end
                    found = 1;
                    break;
                end
            end
            if (!found)
            begin
                marks[top] = 2;
                depth--;
                done++;
            end
        end
        return done;
    endfunction

    // track configuration and transactions on both channels
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t exp_v;
        verdict_t got_v;
        int       cnt;
        int       from;
        int       to;
        if (!rst_n)
        begin
            verdict_q.delete();
            edges_held = 0;
            dropped_flag = 0;
            node_reg = 11'd1;
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wen)
                node_reg = cfg_wdata;
            cnt = int'(node_reg);
            if (cnt < 1)
                cnt = 1;
            if (cnt > scc_pkg::MAX_NODES)
                cnt = scc_pkg::MAX_NODES;
            // input transaction
            if (s_tvalid && s_tready)
            begin
                from = int'(s_tdata[10:0]);
                to = int'(s_tdata[21:11]);
                case (s_tuser)
                    scc_pkg::FUNC_ADD:
                    begin
                        if (from < 1 || from > cnt || to < 1 || to > cnt ||
                            edges_held >= scc_pkg::MAX_EDGES)
                            dropped_flag = 1;
                        else
                        begin
                            src_mem[edges_held] = 11'(from);
                            dst_mem[edges_held] = 11'(to);
                            edges_held++;
                        end
                    end
                    scc_pkg::FUNC_CLEAR:
                    begin
                        edges_held = 0;
                        dropped_flag = 0;
                    end
                    scc_pkg::FUNC_CHECK:
                    begin
                        exp_v.connected = (walk_count(1, cnt) == cnt) &&
                                          (walk_count(0, cnt) == cnt);
                        exp_v.dropped = dropped_flag;
                        verdict_q.insert(verdict_q.size(), exp_v);
                    end
                    default:
                    begin
                    end
                endcase
            end
            // result transaction
            if (m_tvalid && m_tready)
            begin
                got_v.connected = m_tdata[0];
                got_v.dropped = m_tdata[1];
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: expected none, got %b",
                                 m_tdata);
                end
                else
                begin
                    exp_v = verdict_q.pop_front();
                    if (got_v !== exp_v)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("verdict mismatch: expected conn=%b err=%b, got conn=%b err=%b",
                                     exp_v.connected, exp_v.dropped,
                                     got_v.connected, got_v.dropped);
                    end
                end
            end
            fail_count <= mismatches;
            pending <= verdict_q.size();
        end
    end

endmodule

// File: sim/strong_connectivity_check_tb.sv
// testbench top for the strong connectivity block: stimulus, configuration and verdict
// depends on scc_pkg, the block and strong_connectivity_check_checker
`timescale 1ns / 100ps

module strong_connectivity_check_tb;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int         WATCHDOG  = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          sink_stall;
    bit          no_idle;
    int          items_sent;
    int          edges_sent;

    strong_connectivity_check uut (
        .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    strong_connectivity_check_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_stall <= 0;
        end
        else if (sink_stall > 0)
        begin
            m_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                sink_stall <= gap_len();
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one input transaction, returns at the accepting edge
    task automatic send_item(logic [1:0] func, logic [10:0] from, logic [10:0] to);
        int gap;
        gap = no_idle ? 0 : gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {2'b00, to, from};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (func == scc_pkg::FUNC_ADD)
            edges_sent++;
        if (func == scc_pkg::FUNC_CLEAR)
            edges_sent = 0;
    endtask

    // hold off until every verdict has arrived and the block has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_nodes(logic [10:0] value);
        wait_idle();
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    // random graph on n nodes, often built around a cycle so that walks go deep
    task automatic random_phase(int n);
        int perm [];
        int extra;
        int j;
        int t;
        if ($urandom_range(0, 4) != 0 || edges_sent > 150)
            send_item(scc_pkg::FUNC_CLEAR, 11'($urandom), 11'($urandom));
        perm = new[n];
        for (int i = 0; i < n; i++)
            perm[i] = i + 1;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        if ($urandom_range(0, 2) != 0)
        begin
            // cycle, sometimes with one link missing
            j = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, n - 1)) : -1;
            for (int i = 0; i < n; i++)
                if (i != j && n <= 64)
                    send_item(scc_pkg::FUNC_ADD, 11'(perm[i]), 11'(perm[(i + 1) % n]));
        end
        extra = (n > 64) ? $urandom_range(0, 6) : $urandom_range(0, 2 * n + 2);
        for (int i = 0; i < extra; i++)
        begin
            case ($urandom_range(0, 19))
                0: send_item(scc_pkg::FUNC_ADD, 11'($urandom), 11'($urandom));
                1: send_item(FUNC_NONE, 11'($urandom), 11'($urandom));
                2: send_item(scc_pkg::FUNC_ADD, 11'd0, 11'($urandom_range(1, n)));
                default: send_item(scc_pkg::FUNC_ADD, 11'($urandom_range(1, n)),
                                   11'($urandom_range(1, n)));
            endcase
        end
        send_item(scc_pkg::FUNC_CHECK, 11'($urandom), 11'($urandom));
        if ($urandom_range(0, 2) == 0)
            send_item(scc_pkg::FUNC_CHECK, 11'($urandom), 11'($urandom));
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = 11'd0;
        s_tvalid = 1'b0;
        s_tdata = 24'd0;
        s_tuser = scc_pkg::FUNC_ADD;
        no_idle = 0;
        items_sent = 0;
        edges_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset node count, empty graph
        send_item(scc_pkg::FUNC_CHECK, 11'd0, 11'd0);
        set_nodes(11'd4);
        send_item(scc_pkg::FUNC_ADD, 11'd1, 11'd2);
        send_item(scc_pkg::FUNC_ADD, 11'd2, 11'd3);
        send_item(scc_pkg::FUNC_ADD, 11'd3, 11'd4);
        send_item(scc_pkg::FUNC_CHECK, 11'd0, 11'd0);
        send_item(scc_pkg::FUNC_ADD, 11'd4, 11'd1);
        send_item(scc_pkg::FUNC_CHECK, 11'h7ff, 11'h7ff);
        // out of range endpoints and the unused code
        send_item(scc_pkg::FUNC_ADD, 11'd0, 11'd1);
        send_item(scc_pkg::FUNC_ADD, 11'd5, 11'd1);
        send_item(scc_pkg::FUNC_ADD, 11'h7ff, 11'h7ff);
        send_item(FUNC_NONE, 11'd1, 11'd2);
        send_item(scc_pkg::FUNC_CHECK, 11'd0, 11'd0);
        // node count lowered below stored edges
        set_nodes(11'd2);
        send_item(scc_pkg::FUNC_CHECK, 11'd0, 11'd0);
        send_item(scc_pkg::FUNC_CLEAR, 11'd0, 11'd0);
        send_item(scc_pkg::FUNC_CHECK, 11'd0, 11'd0);
        // zero taken as one, oversize taken as the maximum
        set_nodes(11'd0);
        send_item(scc_pkg::FUNC_ADD, 11'd1, 11'd1);
        send_item(scc_pkg::FUNC_CHECK, 11'd0, 11'd0);
        set_nodes(11'h7ff);
        send_item(scc_pkg::FUNC_ADD, 11'd1024, 11'd1);
        send_item(scc_pkg::FUNC_ADD, 11'd1, 11'd1024);
        send_item(scc_pkg::FUNC_ADD, 11'd1025, 11'd1);
        send_item(scc_pkg::FUNC_CHECK, 11'd0, 11'd0);
        set_nodes(11'd1024);
        send_item(scc_pkg::FUNC_CHECK, 11'd0, 11'd0);

        // random phases over many node counts
        while (items_sent < 1650)
        begin
            case ($urandom_range(0, 19))
                0: n = 1024;
                1: n = 1;
                2: n = $urandom_range(17, 64);
                default: n = $urandom_range(2, 12);
            endcase
            if ($urandom_range(0, 2) != 0)
            begin
                if (n == 1024 && $urandom_range(0, 1) == 0)
                    set_nodes(11'h7ff);
                else
                    set_nodes(11'(n));
            end
            else
                wait_idle();
            no_idle = ($urandom_range(0, 5) == 0);
            random_phase(n);
        end
        no_idle = 0;

        // drain
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_datapath.sv
rtl/scc_ctrl.sv
rtl/strong_connectivity_check.sv
rtl/scc_checker.sv
sim/strong_connectivity_check_checker.sv
sim/strong_connectivity_check_tb.sv
